FILE: hdl/nbd_pkg.sv
`default_nettype none

package nbd_pkg;

  // Store geometry
  localparam int unsigned MAX_PARTICLES = 64;
  localparam int unsigned IDX_W         = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned STORE_W       = 96;

  // Configuration register indexes and reset values
  localparam int unsigned           CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0]  CFG_GRAV  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_SOFT  = 1'b1;
  localparam logic [31:0]           GRAV_RST  = 32'd65536;
  localparam logic [31:0]           SOFT_RST  = 32'd655;

  // Datapath widths
  localparam int unsigned MAG_W      = 33;   // |dx|, |dy|
  localparam int unsigned R2_W       = 67;   // dx^2 + dy^2 + eps^2
  localparam int unsigned ROOT_W     = 34;   // floor(sqrt(r2))
  localparam int unsigned PROD_W     = 100;  // widest product (denominator)
  localparam int unsigned NUM_W      = 96;   // G*m*|d|
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned QUO_W      = 57;   // quotient bits kept, cap is 2^56
  localparam int unsigned HI_W       = NUM_W + FRAC_W - QUO_W;
  localparam int unsigned TERM_W     = QUO_W + 1;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned SQ_CW      = $clog2(SQRT_STEPS + 1);
  localparam int unsigned DV_CW      = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] body_mass;
    logic               last_particle;
  } nbd_in_t;

  typedef struct packed {
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               saturated;
    logic               last_result;
  } nbd_out_t;

  typedef enum logic [2:0] {
    MOP_EPS,
    MOP_DX2,
    MOP_DY2,
    MOP_GM,
    MOP_DEN,
    MOP_NX,
    MOP_NY
  } mul_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EPS,
    S_ROW,
    S_TGT,
    S_PAIR,
    S_SRC,
    S_LDX,
    S_DX2,
    S_DY2,
    S_CHK,
    S_SQRT,
    S_DEN,
    S_NX,
    S_NY,
    S_DIV,
    S_NEXT,
    S_OUT
  } nbd_state_e;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic             ld_tgt;
    logic             ld_src;
    logic             mul_go;
    mul_op_e          mul_op;
    logic             sqrt_go;
    logic             div_go;
    logic             acc_clr;
    logic             acc_add;
  } nbd_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic sqrt_busy;
    logic div_busy;
    logic r2_zero;
  } nbd_sts_t;

endpackage

`default_nettype wire

FILE: hdl/nbd_ram.sv
`default_nettype none

module nbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/nbd_ctrl.sv
`default_nettype none

module nbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_last_o,
  output nbd_pkg::nbd_cmd_t cmd_o,
  input  nbd_pkg::nbd_sts_t sts_i
);
  import nbd_pkg::*;

  nbd_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0] last_idx;
  logic             i_last, j_last;

  assign last_idx = cnt_q - CNT_W'(1);
  assign i_last   = (CNT_W'(i_q) == last_idx);
  assign j_last   = (CNT_W'(j_q) == last_idx);

  // State and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    out_last_o  = i_last;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // store the beat unless full
          if (cnt_q < CNT_W'(MAX_PARTICLES)) begin
            cmd_o.wr_en = 1'b1;
            cmd_o.addr  = cnt_q[IDX_W-1:0];
            cnt_d       = cnt_q + CNT_W'(1);
          end
          if (in_last_i) begin
            cmd_o.mul_go = 1'b1;
            cmd_o.mul_op = MOP_EPS;
            state_d      = S_EPS;
          end
        end
      end
      S_EPS: begin
        if (!sts_i.mul_busy) begin
          i_d     = '0;
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = i_q;
        state_d     = S_TGT;
      end
      S_TGT: begin
        cmd_o.ld_tgt  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        j_d           = '0;
        state_d       = S_PAIR;
      end
      S_PAIR: begin
        // skip the self pair
        if (j_q == i_q) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.addr  = j_q;
          state_d     = S_SRC;
        end
      end
      S_SRC: begin
        cmd_o.ld_src = 1'b1;
        state_d      = S_LDX;
      end
      S_LDX: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MOP_DX2;
        state_d      = S_DX2;
      end
      S_DX2: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.mul_op = MOP_DY2;
          state_d      = S_DY2;
        end
      end
      S_DY2: begin
        if (!sts_i.mul_busy) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // drop a coincident pair without softening
        if (sts_i.r2_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.sqrt_go = 1'b1;
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_op  = MOP_GM;
          state_d       = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sts_i.mul_busy && !sts_i.sqrt_busy) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.mul_op = MOP_DEN;
          state_d      = S_DEN;
        end
      end
      S_DEN: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.mul_op = MOP_NX;
          state_d      = S_NX;
        end
      end
      S_NX: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_go = 1'b1;
          cmd_o.mul_op = MOP_NY;
          state_d      = S_NY;
        end
      end
      S_NY: begin
        if (!sts_i.mul_busy) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.acc_add = 1'b1;
          state_d       = S_NEXT;
        end
      end
      S_NEXT: begin
        if (j_last) begin
          state_d = S_OUT;
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = S_PAIR;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (i_last) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_ROW;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/nbd_datapath.sv
`default_nettype none

module nbd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  input  nbd_pkg::nbd_in_t                in_data_i,
  input  nbd_pkg::nbd_cmd_t               cmd_i,
  output nbd_pkg::nbd_sts_t               sts_o,
  output logic signed [31:0]              acc_x_o,
  output logic signed [31:0]              acc_y_o,
  output logic                            sat_o
);
  import nbd_pkg::*;

  localparam logic [QUO_W-1:0] CAP = QUO_W'(1) << (QUO_W - 1);

  // Configuration registers
  logic [31:0] grav_q, soft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAV_RST;
      soft_q <= SOFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAV: grav_q <= cfg_data_i;
        CFG_SOFT: soft_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Particle store: {x, y, mass} per entry
  logic [STORE_W-1:0] rdata;
  logic [31:0]        rd_x, rd_y, rd_m;

  nbd_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.addr),
    .wdata_i ({in_data_i.pos_x, in_data_i.pos_y, in_data_i.body_mass}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[95:64];
  assign rd_y = rdata[63:32];
  assign rd_m = rdata[31:0];

  // Target and source operands
  logic [31:0]      xi_q, yi_q, mj_q;
  logic [MAG_W-1:0] dxm_q, dym_q;
  logic             dxn_q, dyn_q;
  logic [MAG_W-1:0] dx, dy;

  assign dx = {rd_x[31], rd_x} - {xi_q[31], xi_q};
  assign dy = {rd_y[31], rd_y} - {yi_q[31], yi_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_tgt) begin
      xi_q <= rd_x;
      yi_q <= rd_y;
    end
    if (cmd_i.ld_src) begin
      dxn_q <= dx[MAG_W-1];
      dyn_q <= dy[MAG_W-1];
      dxm_q <= dx[MAG_W-1] ? (~dx + MAG_W'(1)) : dx;
      dym_q <= dy[MAG_W-1] ? (~dy + MAG_W'(1)) : dy;
      mj_q  <= rd_m;
    end
  end

  // Shift-add multiplier, one multiplier bit per cycle
  logic [PROD_W-1:0] ma_q, macc_q, m_a, m_init;
  logic [ROOT_W-1:0] mb_q, m_b;
  mul_op_e           mop_q;
  logic              mrun_q, m_done;
  logic [63:0]       eps2_q, gm_q;
  logic [R2_W-1:0]   r2_q;
  logic [ROOT_W-1:0] root_q;
  logic [PROD_W-1:0] den_q;
  logic [NUM_W-1:0]  num_q [2];

  assign m_done = mrun_q && (mb_q == '0);

  always_comb begin
    m_a    = '0;
    m_b    = '0;
    m_init = '0;
    case (cmd_i.mul_op)
      MOP_EPS: begin
        m_a = PROD_W'(soft_q);
        m_b = ROOT_W'(soft_q);
      end
      MOP_DX2: begin
        m_a    = PROD_W'(dxm_q);
        m_b    = ROOT_W'(dxm_q);
        m_init = PROD_W'(eps2_q);
      end
      MOP_DY2: begin
        m_a    = PROD_W'(dym_q);
        m_b    = ROOT_W'(dym_q);
        m_init = macc_q;
      end
      MOP_GM: begin
        m_a = PROD_W'(grav_q);
        m_b = ROOT_W'(mj_q);
      end
      MOP_DEN: begin
        m_a = PROD_W'(r2_q);
        m_b = root_q;
      end
      MOP_NX: begin
        m_a = PROD_W'(gm_q);
        m_b = ROOT_W'(dxm_q);
      end
      MOP_NY: begin
        m_a = PROD_W'(gm_q);
        m_b = ROOT_W'(dym_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrun_q <= 1'b0;
    end else if (cmd_i.mul_go) begin
      mrun_q <= 1'b1;
    end else if (m_done) begin
      mrun_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      ma_q   <= m_a;
      mb_q   <= m_b;
      macc_q <= m_init;
      mop_q  <= cmd_i.mul_op;
    end else if (mrun_q && (mb_q != '0)) begin
      if (mb_q[0]) begin
        macc_q <= macc_q + ma_q;
      end
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  // Route the finished product
  always_ff @(posedge clk_i) begin
    if (m_done) begin
      case (mop_q)
        MOP_EPS: eps2_q   <= macc_q[63:0];
        MOP_DY2: r2_q     <= macc_q[R2_W-1:0];
        MOP_GM:  gm_q     <= macc_q[63:0];
        MOP_DEN: den_q    <= macc_q;
        MOP_NX:  num_q[0] <= macc_q[NUM_W-1:0];
        MOP_NY:  num_q[1] <= macc_q[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Digit-by-digit square root, one result bit per cycle
  logic [2*ROOT_W-1:0] sq_v_q;
  logic [ROOT_W+3:0]   sq_rem_q, sq_t, sq_trial;
  logic [SQ_CW-1:0]    sq_cnt_q;
  logic                sq_ge;

  assign sq_t     = {sq_rem_q[ROOT_W+1:0], sq_v_q[2*ROOT_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_go) begin
      sq_cnt_q <= SQ_CW'(SQRT_STEPS);
    end else if (sq_cnt_q != '0) begin
      sq_cnt_q <= sq_cnt_q - SQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      sq_v_q   <= (2*ROOT_W)'(r2_q);
      sq_rem_q <= '0;
      root_q   <= '0;
    end else if (sq_cnt_q != '0) begin
      sq_v_q   <= sq_v_q << 2;
      sq_rem_q <= sq_ge ? (sq_t - sq_trial) : sq_t;
      root_q   <= {root_q[ROOT_W-2:0], sq_ge};
    end
  end

  // Two restoring divider lanes (x and y) sharing the denominator
  logic [PROD_W-1:0] dv_rem_q [2];
  logic [QUO_W-1:0]  dv_lo_q  [2];
  logic [QUO_W-1:0]  dv_quo_q [2];
  logic              dv_ovf_q [2];
  logic [DV_CW-1:0]  dv_cnt_q;
  logic [PROD_W:0]   dv_t     [2];
  logic              dv_ge    [2];
  logic [PROD_W-1:0] dv_init  [2];
  logic [QUO_W-1:0]  qm       [2];
  logic              qclip    [2];
  logic [TERM_W-1:0] term     [2];
  logic              lane_neg [2];

  assign lane_neg[0] = dxn_q;
  assign lane_neg[1] = dyn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (cmd_i.div_go) begin
      dv_cnt_q <= DV_CW'(DIV_STEPS);
    end else if (dv_cnt_q != '0) begin
      dv_cnt_q <= dv_cnt_q - DV_CW'(1);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign dv_init[l] = PROD_W'(num_q[l][NUM_W-1 -: HI_W]);
    assign dv_t[l]    = {dv_rem_q[l], dv_lo_q[l][QUO_W-1]};
    assign dv_ge[l]   = (dv_t[l] >= {1'b0, den_q});

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_go) begin
        // quotient too big for the kept bits when the high part reaches den
        dv_ovf_q[l] <= (dv_init[l] >= den_q);
        dv_rem_q[l] <= dv_init[l];
        dv_lo_q[l]  <= {num_q[l][QUO_W-FRAC_W-1:0], FRAC_W'(0)};
        dv_quo_q[l] <= '0;
      end else if (dv_cnt_q != '0) begin
        dv_rem_q[l] <= dv_ge[l] ? PROD_W'(dv_t[l] - {1'b0, den_q}) : PROD_W'(dv_t[l]);
        dv_lo_q[l]  <= dv_lo_q[l] << 1;
        dv_quo_q[l] <= {dv_quo_q[l][QUO_W-2:0], dv_ge[l]};
      end
    end

    // Clip the pair term to 2^56 and apply the sign of d
    assign qclip[l] = dv_ovf_q[l] || (dv_quo_q[l] > CAP);
    assign qm[l]    = qclip[l] ? CAP : dv_quo_q[l];
    assign term[l]  = lane_neg[l] ? (~{1'b0, qm[l]} + TERM_W'(1)) : {1'b0, qm[l]};
  end

  // Per-particle sums
  logic [SUM_W-1:0] sum_q [2];
  logic             clip_q;
  logic             hi    [2];
  logic             lo    [2];
  logic [31:0]      sat_v [2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      clip_q   <= 1'b0;
    end else if (cmd_i.acc_add) begin
      sum_q[0] <= sum_q[0] + {{(SUM_W-TERM_W){term[0][TERM_W-1]}}, term[0]};
      sum_q[1] <= sum_q[1] + {{(SUM_W-TERM_W){term[1][TERM_W-1]}}, term[1]};
      clip_q   <= clip_q | qclip[0] | qclip[1];
    end
  end

  // Clamp to the 32 bit result range
  for (genvar l = 0; l < 2; l++) begin : g_clamp
    assign hi[l]    = !sum_q[l][SUM_W-1] && (sum_q[l][SUM_W-2:31] != '0);
    assign lo[l]    = sum_q[l][SUM_W-1] && (sum_q[l][SUM_W-2:31] != '1);
    assign sat_v[l] = hi[l] ? 32'h7FFF_FFFF : (lo[l] ? 32'h8000_0000 : sum_q[l][31:0]);
  end

  assign acc_x_o = sat_v[0];
  assign acc_y_o = sat_v[1];
  assign sat_o   = clip_q | hi[0] | lo[0] | hi[1] | lo[1];

  assign sts_o.mul_busy  = mrun_q;
  assign sts_o.sqrt_busy = (sq_cnt_q != '0);
  assign sts_o.div_busy  = (dv_cnt_q != '0);
  assign sts_o.r2_zero   = (r2_q == '0);

endmodule

`default_nettype wire

FILE: hdl/direct_nbody_acceleration_core.sv
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_stall_o in_data_i  (x, y, mass, last)
// out       out        out_valid_o/out_stall_i out_data_o (acc_x, acc_y, sat, last)
//
// Load beats are accepted back to back. A set of N particles is evaluated pair by
// pair: each pair uses the bit-serial multiplier, which forms six products per
// pair in turn, the 34-step square root and the 57-step divider.
// Reset restores G and epsilon defaults and empties the store (entries undefined).
// in_stall_o is high from the last beat until the final result is taken; a
// stalled result holds on out_data_o.
`default_nettype none

module direct_nbody_acceleration_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nbd_pkg::nbd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nbd_pkg::nbd_out_t             out_data_o
);
  import nbd_pkg::*;

  nbd_cmd_t           cmd;
  nbd_sts_t           sts;
  logic               out_last;
  logic signed [31:0] acc_x, acc_y;
  logic               sat;

  nbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_particle),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_last_o  (out_last),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nbd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .acc_x_o    (acc_x),
    .acc_y_o    (acc_y),
    .sat_o      (sat)
  );

  // Assemble the result beat
  assign out_data_o.acc_x       = acc_x;
  assign out_data_o.acc_y       = acc_y;
  assign out_data_o.saturated   = sat;
  assign out_data_o.last_result = out_last;

endmodule

`default_nettype wire

FILE: hdl/nbd_checker.sv
`default_nettype none

module nbd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input nbd_pkg::nbd_out_t out_data_i
);
  import nbd_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result beat dropped under stall");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("result payload changed under stall");

  // No loading while results are being delivered
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> in_stall_i)
    else $error("input open during result delivery");

  // The final result of a set ends delivery and reopens the input
  a_set_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && out_data_i.last_result |=> !out_valid_i && !in_stall_i)
    else $error("delivery continued after final result");

endmodule

bind direct_nbody_acceleration_core nbd_checker u_nbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
